// ----- src/lts_pkg.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket scheduler package
// Shared constants, event codes and the table write-enable group.
// ----------------------------------------------------------------------------
package lts_pkg;

	localparam int MAX_PROCESSES_DEF = 16;
	localparam int TICKET_BITS_DEF   = 16;
	localparam int WORK_BITS_DEF     = 16;

	localparam int ID_BITS    = 16;
	localparam int IN_BITS    = 16;
	localparam int RAND_BITS  = 32;
	localparam int CFG_BITS   = 8;
	localparam int EV_BITS    = 3;
	localparam int OUT_T_BITS = 20;
	localparam int OUT_W_BITS = 16;
	localparam int CNT_OUT_BITS = 5;

	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_DRAW = 1'b1;

	localparam logic [EV_BITS-1:0] EV_RAN       = 3'd0;
	localparam logic [EV_BITS-1:0] EV_REMOVED   = 3'd1;
	localparam logic [EV_BITS-1:0] EV_REISSUED  = 3'd2;
	localparam logic [EV_BITS-1:0] EV_REDIST    = 3'd3;
	localparam logic [EV_BITS-1:0] EV_NO_DRAW   = 3'd4;
	localparam logic [EV_BITS-1:0] EV_ADDED     = 3'd5;
	localparam logic [EV_BITS-1:0] EV_REJECTED  = 3'd6;

	localparam logic [CFG_BITS-1:0] WORK_PER_WIN_RST = 8'd1;
	localparam logic [ID_BITS-1:0]  NEXT_ID_RST      = 16'd1;

	typedef struct packed {
		logic tix;
		logic init;
		logic work;
		logic id;
	} lts_wr_mask_t;

endpackage

// ----- src/lts_if.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket scheduler channels
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lts_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] new_tickets;
	logic [15:0] new_work;
	logic [31:0] random_value;

	modport source (output valid, func, new_tickets, new_work, random_value, input ready);
	modport sink   (input valid, func, new_tickets, new_work, random_value, output ready);
endinterface

interface lts_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [15:0] winner_id;
	logic [19:0] drawn_ticket;
	logic [15:0] work_left;
	logic [19:0] tickets_left;
	logic [4:0]  process_count;
	logic [19:0] total_tickets;

	modport source (output valid, event_res, winner_id, drawn_ticket, work_left,
		tickets_left, process_count, total_tickets, input ready);
	modport sink   (input valid, event_res, winner_id, drawn_ticket, work_left,
		tickets_left, process_count, total_tickets, output ready);
endinterface

interface lts_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] work_per_win;

	modport source (output valid, work_per_win, input ready);
	modport sink   (input valid, work_per_win, output ready);
endinterface

// ----- src/lts_rem.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket scheduler remainder unit
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lts_rem import lts_pkg::*; #(
	parameter int TOT_BITS = 21
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [RAND_BITS-1:0] dividend,
	input  logic [TOT_BITS-1:0]  divisor,
	output logic                 done,
	output logic [TOT_BITS-1:0]  rem
);
	localparam int STEP_BITS = $clog2(RAND_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] step_q;
	logic [TOT_BITS-1:0]  rem_q;
	logic [RAND_BITS-1:0] dvd_q;
	logic [TOT_BITS-1:0]  dvs_q;
	logic [TOT_BITS:0]    trial;

	assign trial = {rem_q, dvd_q[RAND_BITS-1]};
	assign done  = done_q;
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(RAND_BITS - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[RAND_BITS-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q})
				rem_q <= TOT_BITS'(trial - {1'b0, dvs_q});
			else
				rem_q <= trial[TOT_BITS-1:0];
		end
	end
endmodule

// ----- src/lts_table.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket scheduler process table
// Entry storage with one read index and one masked write index.
// ----------------------------------------------------------------------------
module lts_table import lts_pkg::*; #(
	parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
	parameter int TICKET_BITS   = TICKET_BITS_DEF,
	parameter int WORK_BITS     = WORK_BITS_DEF,
	parameter int TOT_BITS      = 21,
	parameter int IDX_BITS      = 4
) (
	input  logic                   clk,
	input  logic [IDX_BITS-1:0]    rd_idx,
	output logic [TOT_BITS-1:0]    rd_tix,
	output logic [TICKET_BITS-1:0] rd_init,
	output logic [WORK_BITS-1:0]   rd_work,
	output logic [ID_BITS-1:0]     rd_id,
	input  lts_wr_mask_t           wr_mask,
	input  logic [IDX_BITS-1:0]    wr_idx,
	input  logic [TOT_BITS-1:0]    wr_tix,
	input  logic [TICKET_BITS-1:0] wr_init,
	input  logic [WORK_BITS-1:0]   wr_work,
	input  logic [ID_BITS-1:0]     wr_id
);
	logic [TOT_BITS-1:0]    tix_q  [MAX_PROCESSES];
	logic [TICKET_BITS-1:0] init_q [MAX_PROCESSES];
	logic [WORK_BITS-1:0]   work_q [MAX_PROCESSES];
	logic [ID_BITS-1:0]     id_q   [MAX_PROCESSES];

	assign rd_tix  = tix_q[rd_idx];
	assign rd_init = init_q[rd_idx];
	assign rd_work = work_q[rd_idx];
	assign rd_id   = id_q[rd_idx];

	always_ff @(posedge clk) begin
		if (wr_mask.tix)
			tix_q[wr_idx] <= wr_tix;
		if (wr_mask.init)
			init_q[wr_idx] <= wr_init;
		if (wr_mask.work)
			work_q[wr_idx] <= wr_work;
		if (wr_mask.id)
			id_q[wr_idx] <= wr_id;
	end
endmodule

// ----- src/lottery_ticket_scheduler.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket scheduler
// Process table with add and lottery draw commands under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transfer: func 0 adds a process, func 1 runs
//   one draw. rsp returns exactly one result per command. cfg writes
//   work_per_win and is always ready; the user must write it only while
//   the block is idle, which the block itself does not enforce.
//   An add, a rejected add or a draw that finds nothing to draw goes straight
//   to the finish state, which loads the result and returns to idle. A draw
//   runs the remainder unit and walks the table one entry per cycle to find
//   the winner. A winner out of tickets or work causes a walk that reissues
//   tickets or closes the gap after a removal, after a search for the lowest
//   other entry if work alone ran out; one read port sets the walk length.
//   req.ready is high only while the sequencer is idle; a finished result
//   sits in the output register, so a new command is taken while rsp stalls,
//   and the sequencer waits at the end of that command until rsp frees.
//   Reset empties the table, sets the next id to 1 and work_per_win to 1.
// ----------------------------------------------------------------------------
module lottery_ticket_scheduler import lts_pkg::*; #(
	parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
	parameter int TICKET_BITS   = TICKET_BITS_DEF,
	parameter int WORK_BITS     = WORK_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lts_in_if.sink    req,
	lts_out_if.source rsp,
	lts_cfg_if.sink   cfg
);
	localparam int IDX_BITS = $clog2(MAX_PROCESSES);
	localparam int CNT_BITS = $clog2(MAX_PROCESSES + 1);
	localparam int TOT_BITS = TICKET_BITS + CNT_BITS;
	localparam int WCMP_BITS = (WORK_BITS > CFG_BITS) ? WORK_BITS : CFG_BITS;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_DIV     = 4'd1;
	localparam logic [3:0] ST_WALK    = 4'd2;
	localparam logic [3:0] ST_UPD     = 4'd3;
	localparam logic [3:0] ST_REISSUE = 4'd4;
	localparam logic [3:0] ST_MIN     = 4'd5;
	localparam logic [3:0] ST_MINW    = 4'd6;
	localparam logic [3:0] ST_SHIFT   = 4'd7;
	localparam logic [3:0] ST_FIN     = 4'd8;

	logic [3:0]             state_q;
	logic [CNT_BITS-1:0]    count_q;
	logic [TOT_BITS-1:0]    total_q;
	logic [ID_BITS-1:0]     next_id_q;
	logic [CFG_BITS-1:0]    wpw_q;
	logic [CNT_BITS-1:0]    idx_q;
	logic [TOT_BITS-1:0]    acc_q;
	logic [TOT_BITS-1:0]    drawn_q;
	logic [IDX_BITS-1:0]    win_q;
	logic [WORK_BITS-1:0]   win_work_q;
	logic [TOT_BITS-1:0]    win_tix_q;
	logic [WORK_BITS-1:0]   wl_q;
	logic [TOT_BITS-1:0]    tl_q;
	logic [EV_BITS-1:0]     ev_q;
	logic [ID_BITS-1:0]     wid_q;
	logic                   found_q;
	logic [IDX_BITS-1:0]    low_q;
	logic [TOT_BITS-1:0]    low_tix_q;
	logic                   out_valid_q;

	logic                   in_acc;
	logic                   full;
	logic                   can_draw;
	logic                   rem_start;
	logic                   rem_done;
	logic [TOT_BITS-1:0]    rem_val;
	logic [TICKET_BITS-1:0] add_t;
	logic [WORK_BITS-1:0]   add_w;
	logic [CNT_BITS-1:0]    idx_nxt;
	logic                   last;
	logic [TOT_BITS-1:0]    acc_walk;
	logic [TOT_BITS-1:0]    acc_init;
	logic [WCMP_BITS-1:0]   w_ext;
	logic [WCMP_BITS-1:0]   p_ext;
	logic [WORK_BITS-1:0]   new_w;
	logic [TOT_BITS-1:0]    new_t;
	logic                   out_load;

	logic [IDX_BITS-1:0]    rd_idx;
	logic [TOT_BITS-1:0]    rd_tix;
	logic [TICKET_BITS-1:0] rd_init;
	logic [WORK_BITS-1:0]   rd_work;
	logic [ID_BITS-1:0]     rd_id;
	lts_wr_mask_t           wr_mask;
	logic [IDX_BITS-1:0]    wr_idx;
	logic [TOT_BITS-1:0]    wr_tix;
	logic [TICKET_BITS-1:0] wr_init;
	logic [WORK_BITS-1:0]   wr_work;
	logic [ID_BITS-1:0]     wr_id;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign in_acc    = req.valid && req.ready;
	assign full      = (count_q >= CNT_BITS'(MAX_PROCESSES));
	assign can_draw  = (count_q != '0) && (total_q != '0);
	assign rem_start = in_acc && (req.func == FUNC_DRAW) && can_draw;

	// Zero on add is raised to one
	always_comb begin
		add_t = TICKET_BITS'(req.new_tickets);
		add_w = WORK_BITS'(req.new_work);
		if (add_t == '0)
			add_t = TICKET_BITS'(1);
		if (add_w == '0)
			add_w = WORK_BITS'(1);
	end

	assign idx_nxt  = CNT_BITS'(idx_q + 1'b1);
	assign last     = (idx_nxt >= count_q);
	assign acc_walk = TOT_BITS'(acc_q + rd_tix);
	assign acc_init = TOT_BITS'(acc_q + TOT_BITS'(rd_init));
	assign rd_idx   = (state_q == ST_SHIFT) ? idx_nxt[IDX_BITS-1:0] : idx_q[IDX_BITS-1:0];

	// Winner decay; a zero work_per_win leaves work untouched
	always_comb begin
		w_ext = WCMP_BITS'(win_work_q);
		p_ext = WCMP_BITS'(wpw_q);
		if (w_ext > p_ext)
			new_w = WORK_BITS'(w_ext - p_ext);
		else if (wpw_q != '0)
			new_w = '0;
		else
			new_w = win_work_q;
		new_t = (win_tix_q != '0) ? TOT_BITS'(win_tix_q - 1'b1) : win_tix_q;
	end

	always_comb begin
		wr_mask = '0;
		wr_idx  = idx_q[IDX_BITS-1:0];
		wr_tix  = rd_tix;
		wr_init = rd_init;
		wr_work = rd_work;
		wr_id   = rd_id;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (req.func == FUNC_ADD) && !full) begin
					wr_mask = '{tix: 1'b1, init: 1'b1, work: 1'b1, id: 1'b1};
					wr_idx  = count_q[IDX_BITS-1:0];
					wr_tix  = TOT_BITS'(add_t);
					wr_init = add_t;
					wr_work = add_w;
					wr_id   = next_id_q;
				end
			end
			ST_UPD: begin
				wr_mask.tix  = 1'b1;
				wr_mask.work = 1'b1;
				wr_idx       = win_q;
				wr_tix       = new_t;
				wr_work      = new_w;
			end
			ST_REISSUE: begin
				wr_mask.tix = 1'b1;
				wr_tix      = TOT_BITS'(rd_init);
			end
			ST_MINW: begin
				wr_mask.tix = found_q;
				wr_idx      = low_q;
				wr_tix      = TOT_BITS'(low_tix_q + tl_q);
			end
			ST_SHIFT: begin
				// Pull the next entry down over this one
				if (!last)
					wr_mask = '{tix: 1'b1, init: 1'b1, work: 1'b1, id: 1'b1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpw_q <= WORK_PER_WIN_RST;
		end else if (cfg.valid && cfg.ready) begin
			wpw_q <= cfg.work_per_win;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			total_q   <= '0;
			next_id_q <= NEXT_ID_RST;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (req.func == FUNC_ADD) begin
							if (!full) begin
								count_q   <= CNT_BITS'(count_q + 1'b1);
								total_q   <= TOT_BITS'(total_q + TOT_BITS'(add_t));
								next_id_q <= ID_BITS'(next_id_q + 1'b1);
							end
							state_q <= ST_FIN;
						end else if (can_draw) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_DIV: begin
					if (rem_done)
						state_q <= ST_WALK;
				end
				ST_WALK: begin
					if ((acc_walk >= drawn_q) || last)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (win_tix_q != '0)
						total_q <= TOT_BITS'(total_q - 1'b1);
					if (new_w == '0 && new_t == '0)
						state_q <= ST_SHIFT;
					else if (new_t == '0)
						state_q <= ST_REISSUE;
					else if (new_w == '0)
						state_q <= ST_MIN;
					else
						state_q <= ST_FIN;
				end
				ST_REISSUE: begin
					if (last) begin
						total_q <= acc_init;
						state_q <= ST_FIN;
					end
				end
				ST_MIN: begin
					if (last)
						state_q <= ST_MINW;
				end
				ST_MINW: begin
					// Drop the leftover when no other entry can take it
					if (!found_q)
						total_q <= TOT_BITS'(total_q - tl_q);
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (last) begin
						count_q <= CNT_BITS'(count_q - 1'b1);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				drawn_q <= '0;
				wid_q   <= '0;
				wl_q    <= '0;
				tl_q    <= '0;
				if (req.func == FUNC_ADD) begin
					ev_q <= full ? EV_REJECTED : EV_ADDED;
					if (!full) begin
						wid_q <= next_id_q;
						wl_q  <= add_w;
						tl_q  <= TOT_BITS'(add_t);
					end
				end else begin
					ev_q <= EV_NO_DRAW;
				end
			end
			ST_DIV: begin
				drawn_q <= TOT_BITS'(rem_val + 1'b1);
				idx_q   <= '0;
				acc_q   <= '0;
			end
			ST_WALK: begin
				acc_q      <= acc_walk;
				idx_q      <= idx_nxt;
				win_q      <= idx_q[IDX_BITS-1:0];
				win_work_q <= rd_work;
				win_tix_q  <= rd_tix;
				wid_q      <= rd_id;
			end
			ST_UPD: begin
				wl_q    <= new_w;
				tl_q    <= new_t;
				idx_q   <= '0;
				acc_q   <= '0;
				found_q <= 1'b0;
				if (new_w == '0 && new_t == '0) begin
					ev_q  <= EV_REMOVED;
					idx_q <= CNT_BITS'(win_q);
				end else if (new_t == '0) begin
					ev_q <= EV_REISSUED;
				end else if (new_w == '0) begin
					ev_q <= EV_REDIST;
				end else begin
					ev_q <= EV_RAN;
				end
			end
			ST_REISSUE: begin
				acc_q <= acc_init;
				idx_q <= idx_nxt;
			end
			ST_MIN: begin
				if ((idx_q[IDX_BITS-1:0] != win_q) && (!found_q || rd_tix < low_tix_q)) begin
					found_q   <= 1'b1;
					low_q     <= idx_q[IDX_BITS-1:0];
					low_tix_q <= rd_tix;
				end
				idx_q <= idx_nxt;
			end
			ST_MINW: begin
				idx_q <= CNT_BITS'(win_q);
			end
			ST_SHIFT: begin
				idx_q <= idx_nxt;
			end
			default: begin
			end
		endcase
	end

	// Output register: hold until the transfer completes
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.event_res     <= ev_q;
			rsp.winner_id     <= wid_q;
			rsp.drawn_ticket  <= OUT_T_BITS'(drawn_q);
			rsp.work_left     <= OUT_W_BITS'(wl_q);
			rsp.tickets_left  <= OUT_T_BITS'(tl_q);
			rsp.process_count <= CNT_OUT_BITS'(count_q);
			rsp.total_tickets <= OUT_T_BITS'(total_q);
		end
	end

	assign rsp.valid = out_valid_q;

	lts_rem #(
		.TOT_BITS(TOT_BITS)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (req.random_value),
		.divisor  (total_q),
		.done     (rem_done),
		.rem      (rem_val)
	);

	lts_table #(
		.MAX_PROCESSES (MAX_PROCESSES),
		.TICKET_BITS   (TICKET_BITS),
		.WORK_BITS     (WORK_BITS),
		.TOT_BITS      (TOT_BITS),
		.IDX_BITS      (IDX_BITS)
	) u_table (
		.clk     (clk),
		.rd_idx  (rd_idx),
		.rd_tix  (rd_tix),
		.rd_init (rd_init),
		.rd_work (rd_work),
		.rd_id   (rd_id),
		.wr_mask (wr_mask),
		.wr_idx  (wr_idx),
		.wr_tix  (wr_tix),
		.wr_init (wr_init),
		.wr_work (wr_work),
		.wr_id   (wr_id)
	);
endmodule

// ----- src/lts_checker.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket scheduler checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module lts_checker import lts_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  event_res,
	input logic [15:0] winner_id,
	input logic [19:0] drawn_ticket,
	input logic [15:0] work_left,
	input logic [19:0] tickets_left
);
	// Busy in the cycle after a command transfer
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted back to back");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(event_res) && $stable(winner_id)))
		else $error("stalled result changed");

	a_no_draw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == EV_NO_DRAW) |->
		(winner_id == '0 && drawn_ticket == '0 && work_left == '0 && tickets_left == '0))
		else $error("no-draw result carries data");

	a_ran_keeps_both: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == EV_RAN) |->
		(work_left != '0 && tickets_left != '0 && drawn_ticket != '0))
		else $error("ran result with exhausted winner");
endmodule

bind lottery_ticket_scheduler lts_checker u_lts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.event_res    (rsp.event_res),
	.winner_id    (rsp.winner_id),
	.drawn_ticket (rsp.drawn_ticket),
	.work_left    (rsp.work_left),
	.tickets_left (rsp.tickets_left)
);
